// ===== rtl/pcd_pkg.sv =====
package pcd_pkg;

  localparam int ENTRY_INDEX_W  = 6;
  localparam int ENTRY_LENGTH_W = 5;
  localparam int ENTRY_CODE_W   = 29;
  localparam int STREAM_WORD_W  = 32;
  localparam int VALID_BITS_W   = 6;
  localparam int SYMBOL_INDEX_W = 6;
  localparam int ENTRIES_W      = 7;

  // table depth and stream word width follow the index and word fields
  localparam int TABLE_DEPTH    = 64;
  localparam int WORD_BITS      = 32;

  localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 7'd64;

  // func codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  typedef struct packed {
    logic                      func;
    logic [ENTRY_INDEX_W-1:0]  entry_index;
    logic [ENTRY_LENGTH_W-1:0] entry_length;
    logic [ENTRY_CODE_W-1:0]   entry_code;
    logic [STREAM_WORD_W-1:0]  stream_word;
    logic [VALID_BITS_W-1:0]   valid_bits;
  } pcd_in_t;

  typedef struct packed {
    logic [SYMBOL_INDEX_W-1:0] symbol_index;
    logic                      no_match_error;
    logic                      last;
  } pcd_out_t;

  typedef struct packed {
    logic [ENTRY_LENGTH_W-1:0] length;
    logic [ENTRY_CODE_W-1:0]   code;
  } pcd_entry_t;

  // sequencer -> result stage
  typedef struct packed {
    logic                      req;    // new result ready
    logic                      flush;  // word finished
    logic [SYMBOL_INDEX_W-1:0] symbol_index;
    logic                      no_match_error;
  } pcd_res_req_t;

endpackage

// ===== rtl/pcd_table_ram.sv =====
module pcd_table_ram #(
  parameter int DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [$clog2(DEPTH)-1:0]          wr_addr,
  input  pcd_pkg::pcd_entry_t               wr_data,
  input  logic [$clog2(DEPTH)-1:0]          rd_addr,
  output pcd_pkg::pcd_entry_t               rd_data
);
  import pcd_pkg::*;

  pcd_entry_t mem [DEPTH];
  pcd_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/pcd_match.sv =====
module pcd_match #(
  parameter int MAX_CODE_LEN = 29
) (
  input  pcd_pkg::pcd_entry_t                entry,
  input  logic [MAX_CODE_LEN-1:0]            acc,
  input  logic [$clog2(MAX_CODE_LEN+1)-1:0]  cnt,
  output logic                               hit
);
  import pcd_pkg::*;

  localparam int CNT_W = $clog2(MAX_CODE_LEN + 1);
  localparam int CW    = (ENTRY_CODE_W > MAX_CODE_LEN) ? ENTRY_CODE_W : MAX_CODE_LEN;
  localparam int LW    = (ENTRY_LENGTH_W > CNT_W) ? ENTRY_LENGTH_W : CNT_W;

  logic [CW-1:0] code_ext;
  logic [CW-1:0] acc_ext;
  logic [CW-1:0] mask;
  logic          len_ok;

  // code bits above the entry length are don't-care
  always_comb begin
    code_ext = CW'(entry.code);
    acc_ext  = CW'(acc);
    mask     = ~({CW{1'b1}} << cnt);
    len_ok   = (entry.length != '0) && (LW'(entry.length) == LW'(cnt));
    hit      = len_ok && ((code_ext & mask) == acc_ext);
  end

endmodule

// ===== rtl/pcd_out_stage.sv =====
module pcd_out_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pcd_pkg::pcd_res_req_t req,
  output logic                  done,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pcd_pkg::pcd_out_t     out_data
);
  import pcd_pkg::*;

  // one result is held back until it is known whether it ends the word
  logic                      hold_vld_r;
  logic [SYMBOL_INDEX_W-1:0] hold_idx_r;
  logic                      hold_err_r;
  logic                      out_valid_r;
  pcd_out_t                  out_data_r;
  logic                      slot_free;
  logic                      push;

  always_comb begin
    slot_free = !out_valid_r || !out_stall;
    done      = (req.req || req.flush) && (!hold_vld_r || slot_free);
    push      = hold_vld_r && slot_free && (req.req || req.flush);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (done && req.req) begin
        hold_vld_r <= 1'b1;
      end else if (done && req.flush) begin
        hold_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data_r.symbol_index   <= hold_idx_r;
      out_data_r.no_match_error <= hold_err_r;
      out_data_r.last           <= req.flush;
    end
    if (done && req.req) begin
      hold_idx_r <= req.symbol_index;
      hold_err_r <= req.no_match_error;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/prefix_code_table_decoder_core.sv =====
// Prefix-code decoder with a loadable code table. A load transaction (func = 0)
// writes one table entry (length, right-aligned code) and clears the bit
// accumulator. A decode transaction (func = 1) brings a stream word whose
// leading valid_bits bits are consumed MSB first. Each bit is appended to the
// accumulator, then the table is scanned from entry 0 upward through one read
// port and one comparator, one entry per cycle; the first entry whose length
// and code match is emitted as symbol_index and the accumulator clears.
// Reaching MAX_CODE_LEN bits without a match emits an error result
// (no_match_error = 1, symbol_index = 0). The last result of a word has
// last = 1; a word that yields nothing emits nothing. The scan for each stream
// bit covers up to min(entries_in_use, TABLE_DEPTH) entries; a hit ends the
// scan at the matching entry. A result waits while the output is stalled.
// in_stall is high for the whole decode. Table entries hold no reset value:
// every entry that can be searched must be loaded before decoding.
// entries_in_use may only be written while the block is idle.
module prefix_code_table_decoder_core #(
  parameter int MAX_CODE_LEN = 29
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pcd_pkg::pcd_in_t                    in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output pcd_pkg::pcd_out_t                   out_data,
  // configuration: entries_in_use
  input  logic                                cfg_we,
  input  logic [pcd_pkg::ENTRIES_W-1:0]       cfg_wdata
);
  import pcd_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int LIM_W = $clog2(TABLE_DEPTH + 1);
  localparam int CNT_W = $clog2(MAX_CODE_LEN + 1);
  localparam int REM_W = $clog2(WORD_BITS + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BIT   = 3'd1;  // append next stream bit
  localparam logic [2:0] S_SCAN  = 3'd2;  // compare one entry per cycle
  localparam logic [2:0] S_RES   = 3'd3;  // hand result to output stage
  localparam logic [2:0] S_FLUSH = 3'd4;  // word done, release held result

  logic [2:0]                state_r, state_nxt;
  logic [WORD_BITS-1:0]      word_r, word_nxt;
  logic [REM_W-1:0]          rem_r, rem_nxt;
  logic [MAX_CODE_LEN-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [IDX_W-1:0]          cmp_idx_r, cmp_idx_nxt;
  logic [SYMBOL_INDEX_W-1:0] res_idx_r, res_idx_nxt;
  logic                      res_err_r, res_err_nxt;
  logic [ENTRIES_W-1:0]      entries_r;

  logic [LIM_W-1:0]          lim;
  logic                      in_acc;
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_rd_addr;
  pcd_entry_t                ram_wdata;
  pcd_entry_t                ram_rdata;
  logic                      hit;
  logic                      scan_last;
  pcd_res_req_t              res_req;
  logic                      res_done;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= ENTRIES_RESET;
    end else if (cfg_we) begin
      entries_r <= cfg_wdata;
    end
  end

  // entries searched, saturated at the table depth
  always_comb begin
    if (int'(entries_r) > TABLE_DEPTH) begin
      lim = LIM_W'(TABLE_DEPTH);
    end else begin
      lim = LIM_W'(entries_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Table memory and shared comparator
  // ---------------------------------------------------------------------------
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // loads past the table depth are dropped
  assign ram_we    = in_acc && (in_data.func == FUNC_LOAD) &&
                     (int'(in_data.entry_index) < TABLE_DEPTH);
  assign ram_wdata = '{length: in_data.entry_length, code: in_data.entry_code};

  // scan reads run one entry ahead of the compare
  assign ram_rd_addr = (state_r == S_SCAN) ? cmp_idx_r + 1'b1 : '0;

  pcd_table_ram #(
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (IDX_W'(in_data.entry_index)),
    .wr_data (ram_wdata),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rdata)
  );

  pcd_match #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_match (
    .entry (ram_rdata),
    .acc   (acc_r),
    .cnt   (cnt_r),
    .hit   (hit)
  );

  assign scan_last = (lim == '0) || ((LIM_W'(cmp_idx_r) + LIM_W'(1)) == lim);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt   = state_r;
    word_nxt    = word_r;
    rem_nxt     = rem_r;
    acc_nxt     = acc_r;
    cnt_nxt     = cnt_r;
    cmp_idx_nxt = cmp_idx_r;
    res_idx_nxt = res_idx_r;
    res_err_nxt = res_err_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.func == FUNC_LOAD) begin
            acc_nxt = '0;
            cnt_nxt = '0;
          end else begin
            word_nxt = WORD_BITS'(in_data.stream_word);
            if (int'(in_data.valid_bits) > WORD_BITS) begin
              rem_nxt = REM_W'(WORD_BITS);
            end else begin
              rem_nxt = REM_W'(in_data.valid_bits);
            end
            state_nxt = S_BIT;
          end
        end
      end
      S_BIT: begin
        if (rem_r == '0) begin
          state_nxt = S_FLUSH;
        end else begin
          acc_nxt     = {acc_r[MAX_CODE_LEN-2:0], word_r[WORD_BITS-1]};
          cnt_nxt     = cnt_r + 1'b1;
          word_nxt    = word_r << 1;
          rem_nxt     = rem_r - 1'b1;
          cmp_idx_nxt = '0;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit && (lim != '0)) begin
          // lowest matching entry wins
          res_idx_nxt = SYMBOL_INDEX_W'(cmp_idx_r);
          res_err_nxt = 1'b0;
          acc_nxt     = '0;
          cnt_nxt     = '0;
          state_nxt   = S_RES;
        end else if (scan_last) begin
          if (cnt_r == CNT_W'(MAX_CODE_LEN)) begin
            res_idx_nxt = '0;
            res_err_nxt = 1'b1;
            acc_nxt     = '0;
            cnt_nxt     = '0;
            state_nxt   = S_RES;
          end else begin
            state_nxt = S_BIT;
          end
        end else begin
          cmp_idx_nxt = cmp_idx_r + 1'b1;
        end
      end
      S_RES: begin
        if (res_done) begin
          state_nxt = S_BIT;
        end
      end
      S_FLUSH: begin
        if (res_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      acc_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r    <= word_nxt;
    rem_r     <= rem_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    res_idx_r <= res_idx_nxt;
    res_err_r <= res_err_nxt;
  end

  // ---------------------------------------------------------------------------
  // Result stage: holds one result back to set last, then registers it out
  // ---------------------------------------------------------------------------
  always_comb begin
    res_req.req            = (state_r == S_RES);
    res_req.flush          = (state_r == S_FLUSH);
    res_req.symbol_index   = res_idx_r;
    res_req.no_match_error = res_err_r;
  end

  pcd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (res_req),
    .done      (res_done),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_CODE_LEN))
    else $error("accumulator count beyond max code length");

  a_acc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r >> cnt_r) == '0)
    else $error("accumulator holds bits above its count");

  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_data.func == FUNC_LOAD)) |=> (cnt_r == '0) && (state_r == S_IDLE))
    else $error("load did not clear the accumulator");

  a_res_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RES) |-> (cnt_r == '0) && (acc_r == '0))
    else $error("result issued without clearing the accumulator");

endmodule
